[sv/dgh_pkg.sv]
package dgh_pkg;

    localparam int NUM_BUCKETS = 1024;
    localparam int WAYS        = 4;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int SIZE_W      = BKT_W + 1;
    localparam int HASH_W      = 64;
    localparam int FSIZE_W     = 64;
    localparam int ID_W        = 16;
    localparam int MEMBER_W    = ID_W + 1;
    localparam int COUNT_W     = 32;

    // The remainder unit retires this many dividend bits per cycle.
    localparam int MOD_DIGITS  = 8;
    localparam int MOD_CYCLES  = HASH_W / MOD_DIGITS;
    localparam int MOD_CNT_W   = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    localparam logic [MEMBER_W-1:0] NO_MEMBER   = MEMBER_W'(1) << ID_W;
    localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;
    localparam logic [SIZE_W-1:0]   SIZE_RESET  = SIZE_W'(NUM_BUCKETS);

    typedef struct packed {
        logic [HASH_W-1:0]   hash_low;
        logic [HASH_W-1:0]   hash_high;
        logic [FSIZE_W-1:0]  file_size;
        logic [COUNT_W-1:0]  group_count;
        logic [ID_W-1:0]     first_id;
        logic [MEMBER_W-1:0] newest;
    } t_slot;

    // One memory row holds every way of a bucket.
    typedef struct packed {
        logic [WAYS-1:0] valid;
        t_slot [WAYS-1:0] slot;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             free;
        logic [WAY_W-1:0] free_way;
    } t_match;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

[sv/dgh_ram.sv]
module dgh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/dgh_mod.sv]
module dgh_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dgh_pkg::HASH_W-1:0]  i_dividend,
    input  logic [dgh_pkg::SIZE_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [dgh_pkg::BKT_W-1:0]   o_rem
);
    import dgh_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [HASH_W-1:0]    r_dvd;
    logic [SIZE_W-1:0]    r_div;
    logic [BKT_W-1:0]     r_rem;
    logic [BKT_W-1:0]     n_rem;

    // Restoring remainder, most significant bit first. The partial remainder
    // stays below the divisor, so one compare and subtract settles each bit.
    always_comb begin
        logic [SIZE_W-1:0] t;
        logic [BKT_W-1:0]  r;
        r = r_rem;
        for (int k = 0; k < MOD_DIGITS; k++) begin
            t = {r, r_dvd[HASH_W-1-k]};
            if (t >= r_div) begin
                t = t - r_div;
            end
            r = t[BKT_W-1:0];
        end
        n_rem = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + MOD_CNT_W'(1);
                if (r_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << MOD_DIGITS;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[sv/dgh_match.sv]
module dgh_match (
    input  logic                        i_clk,
    input  dgh_pkg::t_row               i_row,
    input  logic [dgh_pkg::HASH_W-1:0]  i_hash_low,
    input  logic [dgh_pkg::HASH_W-1:0]  i_hash_high,
    input  logic [dgh_pkg::FSIZE_W-1:0] i_file_size,
    output dgh_pkg::t_match             o_match
);
    import dgh_pkg::*;

    logic [WAYS-1:0] w_eq;
    t_match          n_match;
    t_match          r_match;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_eq[w] = i_row.valid[w]
                   && (i_row.slot[w].hash_low  == i_hash_low)
                   && (i_row.slot[w].hash_high == i_hash_high)
                   && (i_row.slot[w].file_size == i_file_size);
        end
    end

    // Walking down from the top way leaves the lowest hit and lowest free way.
    always_comb begin
        n_match = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (w_eq[w]) begin
                n_match.hit     = 1'b1;
                n_match.hit_way = WAY_W'(w);
            end
            if (!i_row.valid[w]) begin
                n_match.free     = 1'b1;
                n_match.free_way = WAY_W'(w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_match <= n_match;
    end

    assign o_match = r_match;

endmodule

[sv/duplicate_grouping_hash_table.sv]
// Channel   Direction  Handshake                     Word
// input     in         i_in_valid / o_in_stall       hash_low, hash_high, file_size, file_id
// output    out        o_out_valid / i_out_stall     bucket, flags, ids and counts
// config    in         i_cfg_valid / o_cfg_ready     table_size
//
// One word is in work at a time; the next is not taken until its result is loaded. Its steps
// are the remainder unit (8 hash bits a cycle), taking the bucket, a row read, a way compare
// and a write-back, which loads the result into the output register when the output side is free.
// After reset a clearing pass writes every one of the 1024 bucket rows, one a cycle,
// while o_in_stall stays high. A stalled result holds the write-back stage, and the
// next input word is taken while a finished result waits in the output register.
module duplicate_grouping_hash_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dgh_pkg::HASH_W-1:0]    i_hash_low,
    input  logic [dgh_pkg::HASH_W-1:0]    i_hash_high,
    input  logic [dgh_pkg::FSIZE_W-1:0]   i_file_size,
    input  logic [dgh_pkg::ID_W-1:0]      i_file_id,

    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dgh_pkg::BKT_W-1:0]     o_bucket_index,
    output logic                          o_is_duplicate,
    output logic                          o_overflow,
    output logic [dgh_pkg::ID_W-1:0]      o_first_file_id,
    output logic [dgh_pkg::MEMBER_W-1:0]  o_previous_member,
    output logic [dgh_pkg::COUNT_W-1:0]   o_group_files,
    output logic [dgh_pkg::COUNT_W-1:0]   o_total_files,
    output logic [dgh_pkg::COUNT_W-1:0]   o_duplicate_files,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dgh_pkg::SIZE_W-1:0]    i_cfg_data
);
    import dgh_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;

    logic [2:0]          r_state;
    logic [BKT_W-1:0]    r_clr_addr;
    logic [SIZE_W-1:0]   r_table_size;
    logic [COUNT_W-1:0]  r_total;
    logic [COUNT_W-1:0]  r_dup;

    logic [HASH_W-1:0]   r_hash_low;
    logic [HASH_W-1:0]   r_hash_high;
    logic [FSIZE_W-1:0]  r_file_size;
    logic [ID_W-1:0]     r_file_id;
    logic [BKT_W-1:0]    r_bucket;

    logic                r_out_valid;
    logic [BKT_W-1:0]    r_o_bucket;
    logic                r_o_dup;
    logic                r_o_ovf;
    logic [ID_W-1:0]     r_o_first;
    logic [MEMBER_W-1:0] r_o_prev;
    logic [COUNT_W-1:0]  r_o_group;
    logic [COUNT_W-1:0]  r_o_total;
    logic [COUNT_W-1:0]  r_o_dupcnt;

    logic                w_accept;
    logic [SIZE_W-1:0]   w_eff_size;
    logic                w_mod_done;
    logic [BKT_W-1:0]    w_mod_rem;
    logic                w_out_free;
    logic                w_upd;

    logic                w_we;
    logic [BKT_W-1:0]    w_waddr;
    logic [ROW_W-1:0]    w_wdata;
    logic                w_re;
    logic [ROW_W-1:0]    w_rdata;
    t_row                w_row;
    t_match              w_match;

    t_row                n_row;
    logic                n_dup;
    logic                n_ovf;
    logic                n_store;
    logic [ID_W-1:0]     n_first;
    logic [MEMBER_W-1:0] n_prev;
    logic [COUNT_W-1:0]  n_group;
    logic [COUNT_W-1:0]  n_total;
    logic [COUNT_W-1:0]  n_dup_cnt;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_upd       = (r_state == S_UPD) && w_out_free;

    // A size of zero behaves as one bucket, anything above the table as the full table.
    always_comb begin
        if (r_table_size == '0) begin
            w_eff_size = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(NUM_BUCKETS)) begin
            w_eff_size = SIZE_W'(NUM_BUCKETS);
        end else begin
            w_eff_size = r_table_size;
        end
    end

    dgh_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_dividend (i_hash_high),
        .i_divisor  (w_eff_size),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    dgh_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_bucket),
        .o_rdata (w_rdata)
    );

    assign w_row = t_row'(w_rdata);

    dgh_match u_match (
        .i_clk       (i_clk),
        .i_row       (w_row),
        .i_hash_low  (r_hash_low),
        .i_hash_high (r_hash_high),
        .i_file_size (r_file_size),
        .o_match     (w_match)
    );

    assign w_re = (r_state == S_RD);

    // Join the matching group, open a group in the free way, or report overflow.
    always_comb begin
        n_row     = w_row;
        n_dup     = 1'b0;
        n_ovf     = 1'b0;
        n_store   = 1'b0;
        n_first   = r_file_id;
        n_prev    = NO_MEMBER;
        n_group   = COUNT_W'(1);
        n_dup_cnt = r_dup;
        n_total   = sat_inc(r_total);
        if (w_match.hit) begin
            n_dup     = 1'b1;
            n_store   = 1'b1;
            n_first   = w_row.slot[w_match.hit_way].first_id;
            n_prev    = w_row.slot[w_match.hit_way].newest;
            n_group   = sat_inc(w_row.slot[w_match.hit_way].group_count);
            n_dup_cnt = sat_inc(r_dup);
            n_row.slot[w_match.hit_way].newest      = {1'b0, r_file_id};
            n_row.slot[w_match.hit_way].group_count = n_group;
        end else if (w_match.free) begin
            n_store = 1'b1;
            n_row.valid[w_match.free_way]            = 1'b1;
            n_row.slot[w_match.free_way].hash_low    = r_hash_low;
            n_row.slot[w_match.free_way].hash_high   = r_hash_high;
            n_row.slot[w_match.free_way].file_size   = r_file_size;
            n_row.slot[w_match.free_way].group_count = COUNT_W'(1);
            n_row.slot[w_match.free_way].first_id    = r_file_id;
            n_row.slot[w_match.free_way].newest      = NO_MEMBER;
        end else begin
            n_ovf = 1'b1;
        end
    end

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_upd && n_store;
            w_waddr = r_bucket;
            w_wdata = ROW_W'(n_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_table_size <= SIZE_RESET;
            r_total      <= '0;
            r_dup        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
            if (w_upd) begin
                r_out_valid <= 1'b1;
                r_total     <= n_total;
                r_dup       <= n_dup_cnt;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + BKT_W'(1);
                    if (r_clr_addr == BKT_W'(NUM_BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_mod_done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hash_low  <= i_hash_low;
            r_hash_high <= i_hash_high;
            r_file_size <= i_file_size;
            r_file_id   <= i_file_id;
        end
        if ((r_state == S_DIV) && w_mod_done) begin
            r_bucket <= w_mod_rem;
        end
        if (w_upd) begin
            r_o_bucket <= r_bucket;
            r_o_dup    <= n_dup;
            r_o_ovf    <= n_ovf;
            r_o_first  <= n_first;
            r_o_prev   <= n_prev;
            r_o_group  <= n_group;
            r_o_total  <= n_total;
            r_o_dupcnt <= n_dup_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_bucket_index    = r_o_bucket;
    assign o_is_duplicate    = r_o_dup;
    assign o_overflow        = r_o_ovf;
    assign o_first_file_id   = r_o_first;
    assign o_previous_member = r_o_prev;
    assign o_group_files     = r_o_group;
    assign o_total_files     = r_o_total;
    assign o_duplicate_files = r_o_dupcnt;

endmodule
